// ===== hw/rtl/active_id_table_swap_remove_top_macros.svh =====
// Assertion macros for the active id table.
`ifndef ACTIVE_ID_TABLE_SWAP_REMOVE_TOP_MACROS_SVH
`define ACTIVE_ID_TABLE_SWAP_REMOVE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define AIDT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define AIDT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AIDT_ASSERT_IMP(lbl, ante, cons)
`define AIDT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/aidt_pkg.sv =====
// Shared types and constants of the active id table.
package aidt_pkg;

  localparam int TABLE_DEPTH_DEF = 16;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_FIND   = 2'd3
  } op_t;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_INVALID      = 3'd1;
  localparam logic [2:0] ST_START_FAILED = 3'd2;
  localparam logic [2:0] ST_NO_MEMORY    = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND    = 3'd4;

  typedef struct packed {
    op_t         op;
    logic [63:0] key;
    logic [31:0] handle;
    logic        start_ok;
    logic        null_handle;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        hit;
    logic [31:0] found_worker;
    logic        now_empty;
    logic        start_dispatcher;
    logic [63:0] new_id;
    logic [4:0]  active_count;
    logic [63:0] any_active_key;
  } res_t;

endpackage

// ===== hw/rtl/aidt_if.sv =====
// Request and result channel interfaces of the active id table.
interface aidt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [63:0] scan_key;
  logic [31:0] worker_handle;
  logic        dispatcher_start_ok;

  modport source (output valid, output opcode, output scan_key, output worker_handle,
                  output dispatcher_start_ok, input ready);
  modport sink (input valid, input opcode, input scan_key, input worker_handle,
                input dispatcher_start_ok, output ready);
endinterface

interface aidt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        hit;
  logic [31:0] found_worker;
  logic        now_empty;
  logic        start_dispatcher;
  logic [63:0] new_id;
  logic [4:0]  active_count;
  logic [63:0] any_active_key;

  modport source (output valid, output status, output hit, output found_worker,
                  output now_empty, output start_dispatcher, output new_id,
                  output active_count, output any_active_key, input ready);
  modport sink (input valid, input status, input hit, input found_worker,
                input now_empty, input start_dispatcher, input new_id,
                input active_count, input any_active_key, output ready);
endinterface

// ===== hw/rtl/aidt_front.sv =====
// Front end: accept requests and classify them into commands.
module aidt_front (
  aidt_in_if.sink          in_ch,
  input  aidt_pkg::q_stat_t q_stat,
  output logic             push,
  output aidt_pkg::cmd_t   push_cmd
);

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && !q_stat.full;

  always_comb begin
    push_cmd             = '0;
    push_cmd.op          = aidt_pkg::op_t'(in_ch.opcode);
    push_cmd.key         = in_ch.scan_key;
    push_cmd.handle      = in_ch.worker_handle;
    push_cmd.start_ok    = in_ch.dispatcher_start_ok;
    push_cmd.null_handle = (in_ch.worker_handle == 32'd0);
  end

endmodule

// ===== hw/rtl/aidt_queue.sv =====
// Short command queue between front and back end.
module aidt_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  aidt_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output aidt_pkg::cmd_t    head_cmd,
  output aidt_pkg::q_stat_t q_stat
);

  aidt_pkg::cmd_t                   ent_r [aidt_pkg::QUEUE_DEPTH];
  logic [aidt_pkg::QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [aidt_pkg::QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [aidt_pkg::QUEUE_CNT_W-1:0] fill_r, fill_nxt;

  assign head_cmd     = ent_r[rd_ptr_r];
  assign q_stat.full  = (fill_r == aidt_pkg::QUEUE_CNT_W'(aidt_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (fill_r == '0);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    unique case ({push, pop})
      2'b10:   fill_nxt = fill_r + 1'b1;
      2'b01:   fill_nxt = fill_r - 1'b1;
      default: fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

// ===== hw/rtl/aidt_back.sv =====
// Back end: table memory, key scan, swap-remove and result register.
module aidt_back #(
  parameter int TABLE_DEPTH = aidt_pkg::TABLE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  aidt_pkg::q_stat_t q_stat,
  input  aidt_pkg::cmd_t    head_cmd,
  output logic              pop,
  aidt_out_if.source        out_ch
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_SWAP = 3'b100
  } state_t;

  function automatic logic [4:0] cnt_out(input logic [CW-1:0] c);
    logic [CW+4:0] ext;
    ext = {5'b0, c};
    return ext[4:0];
  endfunction

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [63:0]     next_id_r, next_id_nxt;
  logic [63:0]     slot0_r, slot0_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  aidt_pkg::cmd_t  cmd_r, cmd_nxt;
  logic [31:0]     hit_hdl_r, hit_hdl_nxt;
  logic            out_valid_r, out_valid_nxt;
  aidt_pkg::res_t  res_r, res_nxt;

  logic [63:0]     key_mem [TABLE_DEPTH];
  logic [31:0]     hdl_mem [TABLE_DEPTH];
  logic [63:0]     rd_key_r;
  logic [31:0]     rd_hdl_r;
  logic            mem_we;
  logic [IW-1:0]   mem_wa;
  logic [63:0]     mem_wkey;
  logic [31:0]     mem_whdl;
  logic [IW-1:0]   rd_addr;
  logic [CW-1:0]   cnt_m1;
  logic            last;

  assign cnt_m1 = cnt_r - 1'b1;
  assign last   = (idx_r == cnt_m1[IW-1:0]);

  always_comb begin
    aidt_pkg::res_t r;
    logic           emit;
    r             = '0;
    emit          = 1'b0;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    next_id_nxt   = next_id_r;
    slot0_nxt     = slot0_r;
    idx_nxt       = idx_r;
    cmd_nxt       = cmd_r;
    hit_hdl_nxt   = hit_hdl_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    res_nxt       = res_r;
    pop           = 1'b0;
    mem_we        = 1'b0;
    mem_wa        = cnt_r[IW-1:0];
    mem_wkey      = head_cmd.key;
    mem_whdl      = head_cmd.handle;
    rd_addr       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_stat.empty && !out_valid_r) begin
          pop     = 1'b1;
          cmd_nxt = head_cmd;
          unique case (head_cmd.op)
            aidt_pkg::OP_ALLOC: begin
              emit             = 1'b1;
              r.new_id         = next_id_r;
              next_id_nxt      = next_id_r + 64'd1;
              r.active_count   = cnt_out(cnt_r);
              r.any_active_key = (cnt_r != '0) ? slot0_r : 64'd0;
            end
            aidt_pkg::OP_ADD: begin
              emit             = 1'b1;
              r.active_count   = cnt_out(cnt_r);
              r.any_active_key = (cnt_r != '0) ? slot0_r : 64'd0;
              priority if (head_cmd.null_handle) begin
                r.status = aidt_pkg::ST_INVALID;
              end else if (cnt_r == '0 && !head_cmd.start_ok) begin
                r.status           = aidt_pkg::ST_START_FAILED;
                r.start_dispatcher = 1'b1;
              end else if (cnt_r >= DEPTH_C) begin
                r.status = aidt_pkg::ST_NO_MEMORY;
              end else begin
                mem_we             = 1'b1;
                cnt_nxt            = cnt_r + 1'b1;
                r.start_dispatcher = (cnt_r == '0);
                r.active_count     = cnt_out(cnt_r + 1'b1);
                if (cnt_r == '0) begin
                  slot0_nxt        = head_cmd.key;
                  r.any_active_key = head_cmd.key;
                end
              end
            end
            default: begin
              if (cnt_r == '0) begin
                emit     = 1'b1;
                r.status = aidt_pkg::ST_NOT_FOUND;
              end else begin
                rd_addr   = '0;
                idx_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        if (rd_key_r == cmd_r.key) begin
          if (cmd_r.op == aidt_pkg::OP_FIND) begin
            emit             = 1'b1;
            r.hit            = 1'b1;
            r.found_worker   = rd_hdl_r;
            r.active_count   = cnt_out(cnt_r);
            r.any_active_key = slot0_r;
          end else if (last) begin
            emit             = 1'b1;
            r.hit            = 1'b1;
            r.found_worker   = rd_hdl_r;
            cnt_nxt          = cnt_m1;
            r.now_empty      = (cnt_m1 == '0);
            r.active_count   = cnt_out(cnt_m1);
            r.any_active_key = (cnt_m1 != '0) ? slot0_r : 64'd0;
          end else begin
            hit_hdl_nxt = rd_hdl_r;
            rd_addr     = cnt_m1[IW-1:0];
            state_nxt   = S_SWAP;
          end
        end else if (last) begin
          emit             = 1'b1;
          r.status         = aidt_pkg::ST_NOT_FOUND;
          r.active_count   = cnt_out(cnt_r);
          r.any_active_key = slot0_r;
        end else begin
          idx_nxt = idx_r + 1'b1;
          rd_addr = idx_r + 1'b1;
        end
      end
      S_SWAP: begin
        emit           = 1'b1;
        mem_we         = 1'b1;
        mem_wa         = idx_r;
        mem_wkey       = rd_key_r;
        mem_whdl       = rd_hdl_r;
        cnt_nxt        = cnt_m1;
        r.hit          = 1'b1;
        r.found_worker = hit_hdl_r;
        r.now_empty    = (cnt_m1 == '0);
        r.active_count = cnt_out(cnt_m1);
        if (idx_r == '0) begin
          slot0_nxt = rd_key_r;
        end
        r.any_active_key = (cnt_m1 == '0) ? 64'd0 :
                           ((idx_r == '0) ? rd_key_r : slot0_r);
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (emit) begin
      out_valid_nxt = 1'b1;
      res_nxt       = r;
      state_nxt     = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[mem_wa] <= mem_wkey;
      hdl_mem[mem_wa] <= mem_whdl;
    end
    rd_key_r <= key_mem[rd_addr];
    rd_hdl_r <= hdl_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      next_id_r   <= 64'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      next_id_r   <= next_id_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r   <= slot0_nxt;
    idx_r     <= idx_nxt;
    cmd_r     <= cmd_nxt;
    hit_hdl_r <= hit_hdl_nxt;
    res_r     <= res_nxt;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = res_r.status;
  assign out_ch.hit              = res_r.hit;
  assign out_ch.found_worker     = res_r.found_worker;
  assign out_ch.now_empty        = res_r.now_empty;
  assign out_ch.start_dispatcher = res_r.start_dispatcher;
  assign out_ch.new_id           = res_r.new_id;
  assign out_ch.active_count     = res_r.active_count;
  assign out_ch.any_active_key   = res_r.any_active_key;

endmodule

// ===== hw/rtl/active_id_table_swap_remove_top.sv =====
// Top level of the active id table with swap-remove.
// Usage:
//   in_ch carries one request per handshake (opcode, scan_key, worker_handle,
//   dispatcher_start_ok); out_ch returns exactly one result per request, in order.
//   Accepted requests enter a two-entry command queue, so in_ch keeps taking
//   requests while a result waits on out_ch; a stalled out_ch fills the queue
//   and then drops in_ch.ready.
//   Allocate and add pass through the command queue and the result register;
//   remove and find also scan the table slots in order up to the match (or all
//   of them on a miss), and a remove that moves the last entry into the freed
//   slot adds a swap step. An empty table answers remove and find without a
//   scan. The back end handles one request at a time; the key scan reads one
//   table slot per cycle through the single read port of the table memory.
//   The back end takes the next command in the cycle after its result is
//   taken, so it does not start a new request before the last one is through.
//   Reset clears the entry count and sets the next id to 1; table contents are
//   left as they are and only written slots are ever read.
`include "active_id_table_swap_remove_top_macros.svh"
module active_id_table_swap_remove_top #(
  parameter int TABLE_DEPTH = aidt_pkg::TABLE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  aidt_in_if.sink    in_ch,
  aidt_out_if.source out_ch
);

  aidt_pkg::q_stat_t q_stat;
  aidt_pkg::cmd_t    push_cmd;
  aidt_pkg::cmd_t    head_cmd;
  logic              push;
  logic              pop;

  aidt_front u_front (
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  aidt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_stat   (q_stat)
  );

  aidt_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .head_cmd (head_cmd),
    .pop      (pop),
    .out_ch   (out_ch)
  );

  `AIDT_ASSERT_IMP(a_hit_ok, out_ch.valid && out_ch.hit, out_ch.status == aidt_pkg::ST_OK && out_ch.found_worker != 32'd0)
  `AIDT_ASSERT_IMP(a_empty_res, out_ch.valid && out_ch.now_empty, out_ch.hit && out_ch.active_count == 5'd0 && out_ch.any_active_key == 64'd0)
  `AIDT_ASSERT_IMP(a_start_res, out_ch.valid && out_ch.start_dispatcher, (out_ch.status == aidt_pkg::ST_OK && out_ch.active_count == 5'd1) || (out_ch.status == aidt_pkg::ST_START_FAILED && out_ch.active_count == 5'd0))
  `AIDT_ASSERT_NXT(a_queue_fill, push && q_stat.empty, !q_stat.empty)

endmodule
